// ===== hdl/pru_pkg.sv =====
// shared types, constants and predictor functions for the png row unfilter
package pru_pkg;

    localparam int MAX_ROW_BYTES   = 4096;
    localparam int MAX_PIXEL_BYTES = 8;
    localparam int HIST_DEPTH      = 8;
    localparam int ADDR_W          = $clog2(MAX_ROW_BYTES);
    localparam int HIST_W          = $clog2(HIST_DEPTH);
    localparam int POS_W           = 13;
    localparam int BPP_W           = 4;
    localparam int ROWB_W          = 13;
    localparam int CFG_W           = 13;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BPP       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'b1;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    // one data beat handed from the row tracker to the reconstruct stage
    typedef struct packed {
        logic [7:0]        data;
        filter_t           filter;
        logic [ADDR_W-1:0] addr;
        logic              a_ok;
        logic              b_ok;
        logic              last;
        logic              bad;
    } pru_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       row_end;
        logic       bad_filter;
    } pru_result_t;

    function automatic logic [7:0] avg_pred(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8:1];
    endfunction

    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [10:0]        pa;
        logic [10:0]        pb;
        logic [10:0]        pc;
        // p - a = b - c, p - b = a - c, p - c = a + b - 2c
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = da + db;
        pa = da[10] ? 11'(-da) : 11'(da);
        pb = db[10] ? 11'(-db) : 11'(db);
        pc = dc[10] ? 11'(-dc) : 11'(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

endpackage

// ===== hdl/pru_line_ram.sv =====
// prior-row line store: one write port, one registered read port
module pru_line_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/pru_row_ctrl.sv =====
// row position tracking, filter byte decode and config checking
module pru_row_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic [7:0]                 data_byte,
    input  logic                       image_start,
    input  logic [pru_pkg::BPP_W-1:0]  cfg_bpp,
    input  logic [pru_pkg::ROWB_W-1:0] cfg_row_bytes,
    output logic                       push,
    output logic                       rd_en,
    output pru_pkg::pru_item_t         item
);
    import pru_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    filter_t          filter_reg, filter_next;
    logic             skip_reg, skip_next;
    logic             prv_reg, prv_next;

    logic             cfg_bad;
    logic [POS_W-1:0] p;
    logic             last;

    assign cfg_bad = (cfg_bpp == '0) || (cfg_bpp > BPP_W'(MAX_PIXEL_BYTES)) ||
                     (cfg_row_bytes == '0) || (cfg_row_bytes > ROWB_W'(MAX_ROW_BYTES)) ||
                     (cfg_row_bytes < ROWB_W'(cfg_bpp));

    assign p    = pos_reg - POS_W'(1);
    assign last = (pos_reg >= POS_W'(cfg_row_bytes));

    always_comb begin
        pos_next    = pos_reg;
        filter_next = filter_reg;
        skip_next   = skip_reg;
        prv_next    = prv_reg;
        push        = 1'b0;
        rd_en       = 1'b0;
        item.data   = data_byte;
        item.filter = filter_reg;
        item.addr   = (p >= POS_W'(MAX_ROW_BYTES)) ? ADDR_W'(MAX_ROW_BYTES - 1) : p[ADDR_W-1:0];
        item.a_ok   = (p >= POS_W'(cfg_bpp));
        item.b_ok   = prv_reg;
        item.last   = last;
        item.bad    = 1'b0;
        if (accept) begin
            if (cfg_bad) begin
                push      = 1'b1;
                item.bad  = 1'b1;
                item.last = 1'b0;
            end else if (pos_reg == '0) begin
                // filter type beat
                if (image_start) begin
                    prv_next = 1'b0;
                end
                pos_next = POS_W'(1);
                if (data_byte > 8'(FILT_PAETH)) begin
                    skip_next   = 1'b1;
                    filter_next = FILT_NONE;
                    push        = 1'b1;
                    item.bad    = 1'b1;
                    item.last   = 1'b0;
                end else begin
                    skip_next   = 1'b0;
                    filter_next = filter_t'(data_byte[2:0]);
                end
            end else begin
                pos_next = last ? '0 : pos_reg + POS_W'(1);
                if (skip_reg) begin
                    if (last) begin
                        skip_next = 1'b0;
                    end
                end else begin
                    push  = 1'b1;
                    rd_en = 1'b1;
                    if (last) begin
                        prv_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            filter_reg <= FILT_NONE;
            skip_reg   <= 1'b0;
            prv_reg    <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            filter_reg <= filter_next;
            skip_reg   <= skip_next;
            prv_reg    <= prv_next;
        end
    end

endmodule

// ===== hdl/pru_recon.sv =====
// reconstruct stage: predictor, neighbor history and line store writeback
module pru_recon (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  pru_pkg::pru_item_t         item_in,
    input  logic                       advance,
    input  logic [7:0]                 rd_data,
    input  logic [pru_pkg::BPP_W-1:0]  cfg_bpp,
    output logic                       busy,
    output pru_pkg::pru_result_t       res,
    output logic                       wr_en,
    output logic [pru_pkg::ADDR_W-1:0] wr_addr,
    output logic [7:0]                 wr_data
);
    import pru_pkg::*;

    logic      valid_reg;
    pru_item_t item_reg;
    logic      fwd_hit_reg;
    logic [7:0] fwd_data_reg;
    logic [7:0] left_hist_reg [HIST_DEPTH];
    logic [7:0] upl_hist_reg  [HIST_DEPTH];

    logic [HIST_W-1:0] tap;
    logic [BPP_W-1:0]  bpp_m1;
    logic [7:0] a, b, c, pred, val;
    logic       fire;

    assign bpp_m1 = cfg_bpp - BPP_W'(1);
    assign tap    = bpp_m1[HIST_W-1:0];
    assign a      = item_reg.a_ok ? left_hist_reg[tap] : 8'd0;
    assign c      = item_reg.a_ok ? upl_hist_reg[tap] : 8'd0;
    // the previous beat may have written the entry read for this one
    assign b      = !item_reg.b_ok ? 8'd0 : (fwd_hit_reg ? fwd_data_reg : rd_data);

    always_comb begin
        case (item_reg.filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = avg_pred(a, b);
            FILT_PAETH: pred = paeth_pred(a, b, c);
            default:    pred = 8'd0;
        endcase
    end

    assign val  = item_reg.data + pred;
    assign fire = valid_reg && advance;
    assign busy = valid_reg;

    assign res.out_byte   = item_reg.bad ? 8'd0 : val;
    assign res.row_end    = item_reg.last && !item_reg.bad;
    assign res.bad_filter = item_reg.bad;

    assign wr_en   = fire && !item_reg.bad;
    assign wr_addr = item_reg.addr;
    assign wr_data = val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg     <= item_in;
            fwd_hit_reg  <= wr_en && (item_reg.addr == item_in.addr);
            fwd_data_reg <= val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                left_hist_reg[k] <= 8'd0;
                upl_hist_reg[k]  <= 8'd0;
            end
        end else if (wr_en) begin
            left_hist_reg[0] <= val;
            upl_hist_reg[0]  <= b;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                left_hist_reg[k] <= left_hist_reg[k-1];
                upl_hist_reg[k]  <= upl_hist_reg[k-1];
            end
        end
    end

endmodule

// ===== hdl/png_row_unfilter_core.sv =====
// Reconstructs PNG scanlines (filters None, Sub, Up, Average, Paeth) from the
// filtered byte stream. One byte is accepted per clock unless the input stalls
// behind a held result; the line store read is issued at acceptance and the
// beat is registered in the reconstruct stage, which computes the byte, writes
// it back and loads it into the output register when the output can take it,
// with a forwarding path for an entry that the previous beat writes as this
// one is read. The output register lets a new beat enter while a result waits.
// The line store needs no clearing pass after reset: reads of the prior row are
// gated by a flag that image_start clears and each reconstructed row end sets.
module png_row_unfilter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_image_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_row_end,
    output logic                          m_bad_filter,
    input  logic                          cfg_we,
    input  logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pru_pkg::CFG_W-1:0]     cfg_wdata
);
    import pru_pkg::*;

    logic [BPP_W-1:0]  bpp_reg;
    logic [ROWB_W-1:0] rowb_reg;
    logic              m_valid_reg, m_valid_next;
    pru_result_t       m_res_reg;

    logic              accept, push, rd_en, busy, s1_fire;
    pru_item_t         item;
    pru_result_t       res;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg  <= BPP_W'(1);
            rowb_reg <= ROWB_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BPP:       bpp_reg  <= cfg_wdata[BPP_W-1:0];
                REG_ROW_BYTES: rowb_reg <= cfg_wdata[ROWB_W-1:0];
                default:       ;
            endcase
        end
    end

    assign s1_fire = busy && (!m_valid_reg || m_ready);
    assign s_ready = !busy || s1_fire;
    assign accept  = s_valid && s_ready;

    pru_row_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .data_byte     (s_data_byte),
        .image_start   (s_image_start),
        .cfg_bpp       (bpp_reg),
        .cfg_row_bytes (rowb_reg),
        .push          (push),
        .rd_en         (rd_en),
        .item          (item)
    );

    pru_line_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (8)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (item.addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    pru_recon u_recon (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (push),
        .item_in (item),
        .advance (s1_fire),
        .rd_data (rd_data),
        .cfg_bpp (bpp_reg),
        .busy    (busy),
        .res     (res),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_res_reg.out_byte;
    assign m_row_end    = m_res_reg.row_end;
    assign m_bad_filter = m_res_reg.bad_filter;

`ifndef SYNTHESIS
    // input side only stalls behind a held result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (busy && m_valid && !m_ready))
        else $error("input stalled without a held result");

    // line store writes only when the reconstruct stage hands off
    a_write_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> s1_fire)
        else $error("line store write without stage advance");

    // flagged results carry a zero byte and no row end
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_filter) |-> (m_out_byte == 8'd0 && !m_row_end))
        else $error("bad filter result carries data");
`endif

endmodule

// ===== bench/png_row_unfilter_core_tb.sv =====
// self-checking bench for png_row_unfilter_core with a row unfilter predictor
module png_row_unfilter_core_tb;
    import pru_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } stream_beat_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_data_byte   = '0;
    logic                 s_image_start = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [7:0]           m_out_byte;
    logic                 m_row_end;
    logic                 m_bad_filter;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_wdata     = '0;

    // stream bytes waiting to be driven and reconstructed bytes waiting to come out
    stream_beat_t stream_q[$];
    pru_result_t  recon_q[$];
    stream_beat_t next_beat;
    pru_result_t  want;
    int           beats_pushed = 0;
    int           beats_open   = 0;
    int           errors       = 0;
    int           gap_left     = 0;
    int           stall_left   = 0;
    bit           idle_on      = 1'b1;

    // unfilter model state
    logic [BPP_W-1:0]  cfg_bpp  = 4'd1;
    logic [ROWB_W-1:0] cfg_rb   = 13'd1;
    logic [7:0]        prev_row [MAX_ROW_BYTES];
    logic [7:0]        left_h   [HIST_DEPTH] = '{default: '0};
    logic [7:0]        up_h     [HIST_DEPTH] = '{default: '0};
    logic [POS_W-1:0]  row_pos  = '0;
    filter_t           row_filt = FILT_NONE;
    bit                prior_ok = 1'b0;
    bit                skipping = 1'b0;
    int                store_extent = 0;

    png_row_unfilter_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_image_start (s_image_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_row_end     (m_row_end),
        .m_bad_filter  (m_bad_filter),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic bit config_bad(input int bpp, input int rb);
        return bpp == 0 || bpp > MAX_PIXEL_BYTES || rb == 0 || rb > MAX_ROW_BYTES || rb < bpp;
    endfunction

    function automatic logic [7:0] paeth_guess(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
        int est;
        int da;
        int db;
        int dc;
        est = int'(a) + int'(b) - int'(c);
        da = est - int'(a);
        db = est - int'(b);
        dc = est - int'(c);
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) begin
            return a;
        end else if (db <= dc) begin
            return b;
        end
        return c;
    endfunction

    // advance the model by one accepted beat and queue the result it should produce, if any
    task automatic unfilter_step(input logic [7:0] din, input logic start);
        int          p;
        int          k;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  pred;
        logic [7:0]  val;
        bit          row_done;
        pru_result_t res;
        a = '0;
        b = '0;
        c = '0;
        res = '0;
        if (config_bad(int'(cfg_bpp), int'(cfg_rb))) begin
            res.bad_filter = 1'b1;
            recon_q.push_back(res);
            return;
        end
        if (row_pos == 0) begin
            if (start) prior_ok = 1'b0;
            row_pos = 1;
            if (din > 8'(FILT_PAETH)) begin
                skipping = 1'b1;
                row_filt = FILT_NONE;
                res.bad_filter = 1'b1;
                recon_q.push_back(res);
                return;
            end
            skipping = 1'b0;
            row_filt = filter_t'(din[2:0]);
            return;
        end
        p = int'(row_pos) - 1;
        row_done = (p + 1 >= int'(cfg_rb));
        row_pos = row_done ? '0 : row_pos + 1'b1;
        if (skipping) begin
            if (row_done) skipping = 1'b0;
            return;
        end
        if (p > MAX_ROW_BYTES - 1) p = MAX_ROW_BYTES - 1;
        if (p >= int'(cfg_bpp)) begin
            a = left_h[int'(cfg_bpp) - 1];
            c = up_h[int'(cfg_bpp) - 1];
        end
        if (prior_ok) b = prev_row[p];
        case (row_filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
            FILT_PAETH: pred = paeth_guess(a, b, c);
            default:    pred = '0;
        endcase
        val = din + pred;
        for (k = HIST_DEPTH - 1; k > 0; k--) begin
            left_h[k] = left_h[k-1];
            up_h[k] = up_h[k-1];
        end
        left_h[0] = val;
        up_h[0] = b;
        prev_row[p] = val;
        if (p + 1 > store_extent) store_extent = p + 1;
        if (row_done) prior_ok = 1'b1;
        res.out_byte = val;
        res.row_end = row_done;
        recon_q.push_back(res);
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 80) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void push_beat(input logic [7:0] data, input logic start);
        stream_q.push_back('{data, start});
        beats_pushed++;
        beats_open++;
    endfunction

    function automatic void push_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            push_beat(8'h00, $urandom_range(0, 11) == 0);
        end else if (r < 15) begin
            push_beat(8'hFF, $urandom_range(0, 11) == 0);
        end else begin
            push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
        end
    endfunction

    function automatic logic [7:0] rand_filter();
        if ($urandom_range(0, 99) < 85) return 8'($urandom_range(FILT_NONE, FILT_PAETH));
        return 8'($urandom_range(8'(FILT_PAETH) + 1, 255));
    endfunction

    task automatic wait_idle();
        while (beats_open != 0 || recon_q.size() != 0) @(posedge aclk);
        // filter beats and swallowed bytes give no result but may still be in flight
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
        if (idx == REG_BPP) begin
            cfg_bpp = BPP_W'(value);
        end else begin
            cfg_rb = ROWB_W'(value);
        end
    endtask

    task automatic run_phase(input int bpp_v, input int rb_v, input int rows, input bit partial);
        bit fresh;
        int p;
        int n;
        int r;
        wait_idle();
        fresh = 1'b0;
        // a longer row may only read prior-row entries that some row has written
        if (!config_bad(bpp_v, rb_v) && prior_ok && rb_v > store_extent) begin
            if (row_pos != 0 && !skipping) rb_v = store_extent;
            fresh = 1'b1;
        end
        idle_on = $urandom_range(0, 3) != 0;
        write_reg(REG_BPP, bpp_v);
        write_reg(REG_ROW_BYTES, rb_v);
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (config_bad(bpp_v, rb_v)) begin
            n = $urandom_range(2, 6);
            repeat (n) push_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
            // finish the row left open by the previous phase
            if (row_pos != 0) begin
                p = int'(row_pos) - 1;
                n = (p + 1 >= rb_v) ? 1 : rb_v - p;
                repeat (n) push_data();
            end
            for (r = 0; r < rows + int'(partial); r++) begin
                push_beat(rand_filter(), fresh || $urandom_range(0, 6) == 0);
                fresh = 1'b0;
                n = (r == rows) ? $urandom_range(0, rb_v - 1) : rb_v;
                repeat (n) push_data();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                unfilter_step(s_data_byte, s_image_start);
                beats_open--;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (stream_q.size() != 0) begin
                    next_beat = stream_q.pop_front();
                    s_valid <= 1'b1;
                    s_data_byte <= next_beat.data;
                    s_image_start <= next_beat.start;
                    gap_left = idle_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (recon_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected beat: byte %02h end %0d bad %0d",
                                 m_out_byte, m_row_end, m_bad_filter);
                    end
                end else begin
                    want = recon_q.pop_front();
                    if (m_out_byte !== want.out_byte || m_row_end !== want.row_end ||
                        m_bad_filter !== want.bad_filter) begin
                        errors++;
                        if (errors <= 10) begin
                            $display({"mismatch: expected byte %02h end %0d bad %0d, ",
                                      "got byte %02h end %0d bad %0d"},
                                     want.out_byte, want.row_end, want.bad_filter,
                                     m_out_byte, m_row_end, m_bad_filter);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    initial begin
        int r;
        int sel;
        int bv;
        int rv;
        int base;
        logic [7:0] filt;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // every filter on a short row, then an unknown filter type
        write_reg(REG_BPP, 2);
        write_reg(REG_ROW_BYTES, 3);
        @(posedge aclk);
        cfg_we <= 1'b0;
        for (r = 0; r < 6; r++) begin
            filt = (r <= int'(FILT_PAETH)) ? 8'(r) : 8'hFF;
            push_beat(filt, r == 0);
            push_beat(8'hFF - 8'(r), 1'b0);
            push_beat(8'(r), r == 2);
            push_beat(8'h80 ^ 8'(r * 8'h35), 1'b0);
        end

        run_phase(1, 1, 3, 1'b0);
        run_phase(0, 5, 1, 1'b0);
        run_phase(15, 8191, 1, 1'b0);
        run_phase(4, 2, 1, 1'b0);
        run_phase(8, 8, 2, 1'b1);

        base = beats_pushed;
        while (beats_pushed - base < 400) begin
            sel = $urandom_range(0, 19);
            bv = $urandom_range(1, MAX_PIXEL_BYTES);
            rv = bv + $urandom_range(0, 8);
            if (sel < 4) begin
                rv = bv + $urandom_range(9, 40);
            end else if (sel == 4) begin
                rv = bv;
            end else if (sel == 5) begin
                bv = 0;
            end else if (sel == 6) begin
                bv = $urandom_range(MAX_PIXEL_BYTES + 1, 15);
            end else if (sel == 7) begin
                rv = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_ROW_BYTES + 1, 8191);
            end else if (sel == 8 && bv > 1) begin
                rv = $urandom_range(1, bv - 1);
            end
            run_phase(bv, rv, $urandom_range(1, 3), $urandom_range(0, 2) == 0);
        end

        // close any open row, then two wide rows at the widest pixel, then two more rows
        run_phase(1, 8, 1, 1'b0);
        run_phase(MAX_PIXEL_BYTES, 48, 2, 1'b0);
        run_phase(3, 7, 2, 1'b0);

        wait_idle();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
